@@ rtl/hld_pkg.sv @@
`timescale 1ns / 1ps

package hld_pkg;

	// header characters
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// xor of the fixed header characters, length byte is added separately
	localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

	// frame hunt phases, code 7 is unused and treated as hunting
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_N     = 3'd1,
		PH_E     = 3'd2,
		PH_R     = 3'd3,
		PH_LEN   = 3'd4,
		PH_COLON = 3'd5,
		PH_BODY  = 3'd6
	} phase_t;

endpackage

@@ rtl/header_length_xor_deframer.sv @@
`timescale 1ns / 1ps

// Deframer for a received byte stream carrying frames of the form
// 'U' 'N' 'E' 'R' <length> ':' <length-1 payload bytes> <checksum>. Each
// payload byte comes out as one word on the master side with tlast low;
// the checksum byte comes out with tlast high and tuser set when the xor of
// the six header bytes and the payload matches it. Header bytes and bytes
// seen while hunting produce no word, a header mismatch re-tests the byte
// as a start 'U', and a length of zero drops the frame. One byte is taken
// per clock: a byte sits in an input register while the phase, byte
// count and running xor are updated in a single step, and the result
// lands in an output register, so the sustained rate is one byte per
// cycle as long as the master side keeps up. While a result waits in the
// output register, bytes that produce no word still pass, and one byte
// that would produce a word is held in the input register.
module header_length_xor_deframer (
	input  logic       clk,
	input  logic       arst_n,
	// slave side
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // rx_byte
	// master side
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // data_byte
	output logic       m_tlast,   // frame_end
	output logic       m_tuser    // checksum_ok
);

	logic            valid_s1;
	logic [7:0]      rx_byte_s1;

	hld_pkg::phase_t phase_q, phase_d;
	logic [7:0]      left_q, left_d;
	logic [7:0]      xor_q, xor_d;

	logic            emit;
	logic            frame_end;
	logic            checksum_ok;
	logic            advance;

	logic            out_valid_q;
	logic [7:0]      data_byte_q;
	logic            frame_end_q;
	logic            checksum_ok_q;

	// the step may retire the input word unless it needs a busy output slot
	assign advance  = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	// next phase, byte count and running xor
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		xor_d   = xor_q;
		unique case (phase_q)
			hld_pkg::PH_N: begin
				if (rx_byte_s1 == hld_pkg::CH_N) begin
					phase_d = hld_pkg::PH_E;
				end else begin
					phase_d = (rx_byte_s1 == hld_pkg::CH_U) ? hld_pkg::PH_N : hld_pkg::PH_HUNT;
				end
			end
			hld_pkg::PH_E: begin
				if (rx_byte_s1 == hld_pkg::CH_E) begin
					phase_d = hld_pkg::PH_R;
				end else begin
					phase_d = (rx_byte_s1 == hld_pkg::CH_U) ? hld_pkg::PH_N : hld_pkg::PH_HUNT;
				end
			end
			hld_pkg::PH_R: begin
				if (rx_byte_s1 == hld_pkg::CH_R) begin
					phase_d = hld_pkg::PH_LEN;
				end else begin
					phase_d = (rx_byte_s1 == hld_pkg::CH_U) ? hld_pkg::PH_N : hld_pkg::PH_HUNT;
				end
			end
			hld_pkg::PH_LEN: begin
				left_d  = rx_byte_s1;
				phase_d = (rx_byte_s1 == 8'd0) ? hld_pkg::PH_HUNT : hld_pkg::PH_COLON;
			end
			hld_pkg::PH_COLON: begin
				if (rx_byte_s1 == hld_pkg::CH_COLON) begin
					xor_d   = hld_pkg::HDR_XOR ^ left_q;
					phase_d = hld_pkg::PH_BODY;
				end else begin
					phase_d = (rx_byte_s1 == hld_pkg::CH_U) ? hld_pkg::PH_N : hld_pkg::PH_HUNT;
				end
			end
			hld_pkg::PH_BODY: begin
				if (left_q > 8'd1) begin
					xor_d  = xor_q ^ rx_byte_s1;
					left_d = left_q - 8'd1;
				end else begin
					left_d  = 8'd0;
					phase_d = hld_pkg::PH_HUNT;
				end
			end
			default: begin
				phase_d = (rx_byte_s1 == hld_pkg::CH_U) ? hld_pkg::PH_N : hld_pkg::PH_HUNT;
			end
		endcase
	end

	// result of the step
	always_comb begin
		emit        = (phase_q == hld_pkg::PH_BODY);
		frame_end   = emit && (left_q <= 8'd1);
		checksum_ok = frame_end && (xor_q == rx_byte_s1);
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hld_pkg::PH_HUNT;
			left_q  <= 8'd0;
			xor_q   <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			xor_q   <= xor_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			data_byte_q   <= rx_byte_s1;
			frame_end_q   <= frame_end;
			checksum_ok_q <= checksum_ok;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_byte_q;
	assign m_tlast  = frame_end_q;
	assign m_tuser  = checksum_ok_q;

endmodule

@@ rtl/hld_checker.sv @@
`timescale 1ns / 1ps

module hld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// a stalled result word holds with its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result word changed");

	// checksum flag only on the word that ends a frame
	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tuser)
		else $error("checksum flag set on payload word");

	// an input word is only refused while a word waits on the master side
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

bind header_length_xor_deframer hld_checker u_hld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
